// ===== hw/rtl/sstf_pkg.sv =====
// Shared types and constants for the shortest-seek-time-first disk scheduler.
// No dependencies; every other file of the block refers to this package.
package sstf_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int TRACK_BITS   = 10;
  localparam int SEEK_BITS    = 16;
  localparam int IDX_BITS     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);

  typedef logic [TRACK_BITS-1:0] track_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [SEEK_BITS-1:0]  seek_t;

  localparam cnt_t  MaxCount = cnt_t'(MAX_REQUESTS);
  localparam seek_t SeekMax  = {SEEK_BITS{1'b1}};

  // Best candidate so far, handed from cell to cell along the chain
  typedef struct packed {
    logic   vld;
    logic   found;
    track_t gap;
    track_t trk;
    idx_t   idx;
  } cand_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic   wr_en;
    idx_t   wr_idx;
    track_t wr_track;
    logic   clr_en;
    idx_t   clr_idx;
    track_t head;
    logic   inject;
  } ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

// ===== hw/rtl/sstf_req_if.sv =====
// Request channel: valid/ready handshake carrying one track request per beat.
// Depends on sstf_pkg for the track width.
interface sstf_req_if;
  logic                   valid;
  logic                   ready;
  logic [sstf_pkg::TRACK_BITS-1:0] track;
  logic                   final_request;

  modport source (output valid, output track, output final_request, input ready);
  modport sink   (input valid, input track, input final_request, output ready);
endinterface

// ===== hw/rtl/sstf_res_if.sv =====
// Result channel: valid/ready handshake carrying one served request per beat.
// Depends on sstf_pkg for the track and seek widths.
interface sstf_res_if;
  logic                            valid;
  logic                            ready;
  logic [sstf_pkg::TRACK_BITS-1:0] served_track;
  logic [sstf_pkg::SEEK_BITS-1:0]  seek_total;
  logic                            run_end;

  modport source (output valid, output served_track, output seek_total, output run_end,
                  input ready);
  modport sink   (input valid, input served_track, input seek_total, input run_end,
                  output ready);
endinterface

// ===== hw/rtl/sstf_disk_scheduler.sv =====
// Top level of the shortest-seek-time-first disk scheduler: sequencer,
// result register and the cell chain. Depends on sstf_pkg, sstf_req_if,
// sstf_res_if and sstf_chain.
//
//  channel   dir  fields                                 beat when
//  req_i     in   track, final_request                   valid && ready
//  res_o     out  served_track, seek_total, run_end      valid && ready
//  cfg       in   cfg_wdata_i (start_head)               cfg_we_i
//
// Loading takes one request per cycle while idle; requests past MAX_REQUESTS are dropped.
// Each pick launches a token from the inject register that then passes through
// every cell of the chain. A pick that finds the result register still full is
// launched again, so a stalled sink costs whole chain passes.
// No new request is taken while a batch is being scheduled.
// Reset clears all pending flags at once; there is no clearing pass.
module sstf_disk_scheduler (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  sstf_pkg::track_t       cfg_wdata_i,
  sstf_req_if.sink               req_i,
  sstf_res_if.source             res_o
);

  sstf_pkg::state_e state_q, state_d;
  sstf_pkg::track_t start_head_q;
  sstf_pkg::cnt_t   count_q;
  sstf_pkg::cnt_t   count_after;
  sstf_pkg::cnt_t   n_q;
  sstf_pkg::cnt_t   served_q;
  sstf_pkg::track_t head_q;
  sstf_pkg::seek_t  seek_q;
  logic             inject_q;
  logic             out_vld_q;
  sstf_pkg::track_t out_trk_q;
  sstf_pkg::seek_t  out_seek_q;
  logic             out_end_q;

  sstf_pkg::ctl_t   ctl;
  sstf_pkg::cand_t  tail;
  logic             in_beat;
  logic             start;
  logic             out_free;
  logic             pick_ok;
  logic             last_pick;
  logic [sstf_pkg::SEEK_BITS:0] seek_sum;
  sstf_pkg::seek_t  seek_next;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q <= '0;
    end else if (cfg_we_i) begin
      start_head_q <= cfg_wdata_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sstf_pkg::ST_IDLE: begin
        if (start) state_d = sstf_pkg::ST_SCAN;
      end
      sstf_pkg::ST_SCAN: begin
        if (pick_ok && last_pick) state_d = sstf_pkg::ST_IDLE;
      end
      default: state_d = sstf_pkg::ST_IDLE;
    endcase
  end

  // Handshake, pick and cell control
  always_comb begin
    req_i.ready  = (state_q == sstf_pkg::ST_IDLE);
    in_beat      = req_i.valid && req_i.ready;
    start        = in_beat && req_i.final_request;
    count_after  = (count_q < sstf_pkg::MaxCount) ? (count_q + 1'b1) : count_q;
    out_free     = !out_vld_q || res_o.ready;
    pick_ok      = (state_q == sstf_pkg::ST_SCAN) && tail.vld && out_free;
    last_pick    = ((served_q + 1'b1) == n_q);
    seek_sum     = {1'b0, seek_q} + (sstf_pkg::SEEK_BITS+1)'(tail.gap);
    seek_next    = seek_sum[sstf_pkg::SEEK_BITS] ? sstf_pkg::SeekMax
                                                 : seek_sum[sstf_pkg::SEEK_BITS-1:0];
    ctl.wr_en    = in_beat && (count_q < sstf_pkg::MaxCount);
    ctl.wr_idx   = count_q[sstf_pkg::IDX_BITS-1:0];
    ctl.wr_track = req_i.track;
    ctl.clr_en   = pick_ok;
    ctl.clr_idx  = tail.idx;
    ctl.head     = head_q;
    ctl.inject   = inject_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sstf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Batch bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      n_q      <= '0;
      served_q <= '0;
      head_q   <= '0;
      seek_q   <= '0;
      inject_q <= 1'b0;
    end else begin
      inject_q <= 1'b0;
      if (start) begin
        count_q  <= '0;
        n_q      <= count_after;
        served_q <= '0;
        head_q   <= start_head_q;
        seek_q   <= '0;
        inject_q <= 1'b1;
      end else if (in_beat) begin
        count_q <= count_after;
      end
      if (pick_ok) begin
        served_q <= served_q + 1'b1;
        head_q   <= tail.trk;
        seek_q   <= last_pick ? '0 : seek_next;
      end
      // Relaunch for the next pick, or retry when the result slot is full
      if ((state_q == sstf_pkg::ST_SCAN) && tail.vld && !(pick_ok && last_pick)) begin
        inject_q <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pick_ok) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pick_ok) begin
      out_trk_q  <= tail.trk;
      out_seek_q <= seek_next;
      out_end_q  <= last_pick;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.served_track = out_trk_q;
  assign res_o.seek_total   = out_seek_q;
  assign res_o.run_end      = out_end_q;

  sstf_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .tail_o (tail)
  );

  // A token that reaches the tail always carries a pending request
  a_tail_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> tail.found)
    else $error("token left the chain without a pick");

  // Tokens only run while scheduling
  a_tail_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> (state_q == sstf_pkg::ST_SCAN))
    else $error("token at tail outside a batch");

  // Never serve more than the batch holds
  a_served_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sstf_pkg::ST_SCAN) |-> (served_q < n_q))
    else $error("served count ran past batch size");

  // Count stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sstf_pkg::MaxCount)
    else $error("request count above capacity");

endmodule

// ===== hw/rtl/sstf_cell.sv =====
// One scheduler cell: holds a request track and its pending flag, and
// updates the passing best-candidate token. Depends on sstf_pkg.
module sstf_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sstf_pkg::idx_t  idx_i,
  input  sstf_pkg::ctl_t  ctl_i,
  input  sstf_pkg::cand_t cand_i,
  output sstf_pkg::cand_t cand_o
);

  sstf_pkg::track_t trk_q;
  logic             pend_q;
  sstf_pkg::track_t gap;
  logic             take;
  sstf_pkg::cand_t  cand_d;
  sstf_pkg::cand_t  cand_q;

  // Load a new request, or drop the pending flag once served
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (ctl_i.wr_en && (ctl_i.wr_idx == idx_i)) begin
      pend_q <= 1'b1;
    end else if (ctl_i.clr_en && (ctl_i.clr_idx == idx_i)) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && (ctl_i.wr_idx == idx_i)) begin
      trk_q <= ctl_i.wr_track;
    end
  end

  // Distance to head; on a tie the later cell wins
  always_comb begin
    gap    = (trk_q >= ctl_i.head) ? (trk_q - ctl_i.head) : (ctl_i.head - trk_q);
    take   = pend_q && (!cand_i.found || (gap <= cand_i.gap));
    cand_d = cand_i;
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.gap   = gap;
      cand_d.trk   = trk_q;
      cand_d.idx   = idx_i;
    end
  end

  // Advance the token one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

// ===== hw/rtl/sstf_chain.sv =====
// Row of MAX_REQUESTS scheduler cells linked head to tail; a token enters
// cell 0 on inject and leaves the last cell carrying the pick. Depends on
// sstf_pkg and sstf_cell.
module sstf_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sstf_pkg::ctl_t  ctl_i,
  output sstf_pkg::cand_t tail_o
);

  sstf_pkg::cand_t link [sstf_pkg::MAX_REQUESTS+1];

  // Fresh token: nothing found yet
  always_comb begin
    link[0]     = '0;
    link[0].vld = ctl_i.inject;
  end

  for (genvar g = 0; g < sstf_pkg::MAX_REQUESTS; g++) begin : g_cell
    sstf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (sstf_pkg::idx_t'(g)),
      .ctl_i  (ctl_i),
      .cand_i (link[g]),
      .cand_o (link[g+1])
    );
  end

  assign tail_o = link[sstf_pkg::MAX_REQUESTS];

endmodule
